[rtl/kbpf_pkg.sv]
// ----------------------------------------------------------------------------
// kbpf_pkg
// Shared widths, register codes and the word types of the pixel fusion block.
// ----------------------------------------------------------------------------
package kbpf_pkg;

  localparam int IDX_W       = 21;
  localparam int PIX_W       = 8;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 2;
  // power of two, at most 2**IDX_W
  localparam int PIXEL_COUNT = 2097152;
  localparam int ADDR_W      = $clog2(PIXEL_COUNT);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_INIT   = 2'd1;

  localparam logic [CFG_W-1:0] PROCESS_GAIN_RST = 24'd6554;
  localparam logic [CFG_W-1:0] NOISE_INIT_RST   = 24'd65536;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [16:0] HALF_Q16 = 17'h08000;

  // divider: restoring, DIV_STEP quotient bits per stage
  localparam int DIV_NUM_W  = 50;
  localparam int DIV_DEN_W  = 34;
  localparam int DIV_Q_W    = 34;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_STEP;

  // per-pixel state word
  typedef struct packed {
    logic [23:0] est;
    logic [31:0] p;
    logic [16:0] k;
    logic [31:0] r;
    logic [7:0]  pb;
  } state_t;

  // per-word context carried down the pipe
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             load;
    logic [PIX_W-1:0] z;
    logic [PIX_W-1:0] blur;
    logic [PIX_W-1:0] bil;
    logic [23:0]      est;
    logic [31:0]      p;
    logic [31:0]      r;
    logic [31:0]      qd;
    logic [7:0]       d;
    logic [31:0]      pp;
  } ctx_t;

endpackage

[rtl/kbpf_div.sv]
// ----------------------------------------------------------------------------
// kbpf_div
// Pipelined restoring divider, DIV_STEP quotient bits per stage, with the
// word context and valid bits travelling alongside.
// ----------------------------------------------------------------------------
module kbpf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [kbpf_pkg::DIV_NUM_W-1:0] num,
  input  logic [kbpf_pkg::DIV_DEN_W-1:0] den,
  input  kbpf_pkg::ctx_t                in_ctx,
  input  logic [kbpf_pkg::ADDR_W-1:0]   probe,
  output logic                          out_vld,
  output logic [kbpf_pkg::DIV_Q_W-1:0]  quo,
  output kbpf_pkg::ctx_t                out_ctx,
  output logic                          hit
);
  import kbpf_pkg::*;

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_DEN_W-1:0]  rem_q   [DIV_STAGES];
  logic [DIV_NUM_W-1:0]  num_q   [DIV_STAGES];
  logic [DIV_Q_W-1:0]    quo_q   [DIV_STAGES];
  logic [DIV_DEN_W-1:0]  den_q   [DIV_STAGES];
  ctx_t                  ctx_q   [DIV_STAGES];

  logic [DIV_DEN_W-1:0]  src_rem [DIV_STAGES];
  logic [DIV_NUM_W-1:0]  src_num [DIV_STAGES];
  logic [DIV_Q_W-1:0]    src_quo [DIV_STAGES];
  logic [DIV_DEN_W-1:0]  src_den [DIV_STAGES];
  ctx_t                  src_ctx [DIV_STAGES];

  logic [DIV_DEN_W-1:0]  rem_next [DIV_STAGES];
  logic [DIV_NUM_W-1:0]  num_next [DIV_STAGES];
  logic [DIV_Q_W-1:0]    quo_next [DIV_STAGES];

  always_comb begin
    src_rem[0] = '0;
    src_num[0] = num;
    src_quo[0] = '0;
    src_den[0] = den;
    src_ctx[0] = in_ctx;
    for (int s = 1; s < DIV_STAGES; s++) begin
      src_rem[s] = rem_q[s-1];
      src_num[s] = num_q[s-1];
      src_quo[s] = quo_q[s-1];
      src_den[s] = den_q[s-1];
      src_ctx[s] = ctx_q[s-1];
    end
  end

  always_comb begin
    logic [DIV_DEN_W:0]   t;
    logic [DIV_DEN_W-1:0] rr;
    logic [DIV_NUM_W-1:0] nn;
    logic [DIV_Q_W-1:0]   qq;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rr = src_rem[s];
      nn = src_num[s];
      qq = src_quo[s];
      for (int b = 0; b < DIV_STEP; b++) begin
        t  = {rr, nn[DIV_NUM_W-1]};
        nn = {nn[DIV_NUM_W-2:0], 1'b0};
        if (t >= {1'b0, src_den[s]}) begin
          t  = t - {1'b0, src_den[s]};
          qq = {qq[DIV_Q_W-2:0], 1'b1};
        end else begin
          qq = {qq[DIV_Q_W-2:0], 1'b0};
        end
        rr = t[DIV_DEN_W-1:0];
      end
      rem_next[s] = rr;
      num_next[s] = nn;
      quo_next[s] = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_q[s] <= rem_next[s];
        num_q[s] <= num_next[s];
        quo_q[s] <= quo_next[s];
        den_q[s] <= src_den[s];
        ctx_q[s] <= src_ctx[s];
      end
    end
  end

  // any word in flight for the probed pixel
  always_comb begin
    hit = 1'b0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (vld[s] && ctx_q[s].idx[ADDR_W-1:0] == probe) hit = 1'b1;
    end
  end

  assign out_vld = vld[DIV_STAGES-1];
  assign quo     = quo_q[DIV_STAGES-1];
  assign out_ctx = ctx_q[DIV_STAGES-1];

endmodule

[rtl/kalman_bilateral_pixel_fusion_top.sv]
// ----------------------------------------------------------------------------
// kalman_bilateral_pixel_fusion_top
// Per-pixel temporal Kalman filter fused with a bilateral value, state held
// in an on-chip store indexed by pixel address.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//  in      | in_valid / in_ready      | pixel_index, raw_pixel, box_blurred,
//          |                          | bilateral_value, load_first
//  out     | out_valid / out_ready    | out_index, denoised_pixel
//
//  one word per clock for distinct pixels while the output word is taken;
//  the two dividers lie in series (noise update, then new gain)
//  a word for a pixel still in flight waits until its predecessor is written
//  back, since each update needs the previous one's state
//  synchronous reset clears valid bits and config registers, not data or the state store
//  the whole pipe holds while the output word is not taken
// ----------------------------------------------------------------------------
module kalman_bilateral_pixel_fusion_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kbpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kbpf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kbpf_pkg::IDX_W-1:0]    pixel_index,
  input  logic [kbpf_pkg::PIX_W-1:0]    raw_pixel,
  input  logic [kbpf_pkg::PIX_W-1:0]    box_blurred,
  input  logic [kbpf_pkg::PIX_W-1:0]    bilateral_value,
  input  logic                          load_first,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kbpf_pkg::IDX_W-1:0]    out_index,
  output logic [kbpf_pkg::PIX_W-1:0]    denoised_pixel
);
  import kbpf_pkg::*;

  logic [CFG_W-1:0] process_gain;
  logic [CFG_W-1:0] noise_init;

  logic adv, hit, acc;
  logic [ADDR_W-1:0] in_addr;

  state_t mem [PIXEL_COUNT];
  state_t rd_q;

  logic s1_vld, s4_vld, s5_vld, s6_vld, s8_vld, s9_vld, s10_vld, s11_vld, s12_vld;
  ctx_t s1_c, s4_c, s5_c, s6_c, s8_c, s9_c, s10_c, s11_c, s12_c;
  ctx_t s1_c_next, s4_c_next, s5_c_next;

  // stage 1 logic
  logic [16:0]          k1;
  logic [7:0]           d1;
  logic [17:0]          den1;
  ctx_t                 c1;
  logic [DIV_NUM_W-1:0] num1;

  logic                 d1_vld, d1_hit, d2_vld, d2_hit;
  logic [DIV_Q_W-1:0]   q1, q2;
  ctx_t                 d1_c, d2_c;

  logic [34:0]          rsum;
  logic [31:0]          r_new;
  logic [39:0]          qdd, s4_qdd;
  logic [40:0]          ppsum;
  logic [DIV_DEN_W-1:0] s6_den;
  logic [DIV_NUM_W-1:0] num2;

  logic [16:0] s8_kn, s9_kn, s10_kn, s11_kn, s12_kn;
  logic [16:0] s8_omk, s10_omk;
  logic [40:0] s9_ma, s11_mc;
  logic [24:0] s9_mb, s11_md;
  logic [48:0] s9_mp;
  logic [40:0] xpsum, xsum;
  logic [48:0] psum;
  logic [23:0] s10_xp, s12_x;
  logic [31:0] s10_pnew, s11_pnew, s12_pnew;

  logic        wr_en;
  state_t      wr_data;
  logic [8:0]  rnd;
  logic [7:0]  pix;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_gain <= PROCESS_GAIN_RST;
      noise_init   <= NOISE_INIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROCESS_GAIN: process_gain <= cfg_data;
        REG_NOISE_INIT:   noise_init   <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign adv      = !out_valid || out_ready;
  assign in_addr  = pixel_index[ADDR_W-1:0];
  assign hit      = (s1_vld  && s1_c.idx[ADDR_W-1:0]  == in_addr) || d1_hit ||
                    (s4_vld  && s4_c.idx[ADDR_W-1:0]  == in_addr) ||
                    (s5_vld  && s5_c.idx[ADDR_W-1:0]  == in_addr) ||
                    (s6_vld  && s6_c.idx[ADDR_W-1:0]  == in_addr) || d2_hit ||
                    (s8_vld  && s8_c.idx[ADDR_W-1:0]  == in_addr) ||
                    (s9_vld  && s9_c.idx[ADDR_W-1:0]  == in_addr) ||
                    (s10_vld && s10_c.idx[ADDR_W-1:0] == in_addr) ||
                    (s11_vld && s11_c.idx[ADDR_W-1:0] == in_addr) ||
                    (s12_vld && s12_c.idx[ADDR_W-1:0] == in_addr);
  assign in_ready = adv && !hit;
  assign acc      = in_valid && in_ready;

  // state store: read on accept, write back as the word leaves the pipe
  always_ff @(posedge clk) begin
    if (wr_en) mem[s12_c.idx[ADDR_W-1:0]] <= wr_data;
    if (adv) rd_q <= mem[in_addr];
  end

  // stage 1: clamp gain, blur change, first divider operands
  always_comb begin
    k1   = (rd_q.k > ONE_Q16) ? ONE_Q16 : rd_q.k;
    d1   = (rd_q.pb > s1_c.blur) ? rd_q.pb - s1_c.blur : s1_c.blur - rd_q.pb;
    den1 = 18'(ONE_Q16) + 18'(k1);
    num1 = DIV_NUM_W'({rd_q.r, 16'h0000}) + DIV_NUM_W'(den1[17:1]);
    c1      = s1_c;
    c1.est  = rd_q.est;
    c1.p    = rd_q.p;
    c1.r    = rd_q.r;
    c1.qd   = 32'(process_gain) * 32'(d1);
    c1.d    = d1;
    c1.pp   = '0;
  end

  kbpf_div u_div_r (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (s1_vld),
    .num     (num1),
    .den     (DIV_DEN_W'(den1)),
    .in_ctx  (c1),
    .probe   (in_addr),
    .out_vld (d1_vld),
    .quo     (q1),
    .out_ctx (d1_c),
    .hit     (d1_hit)
  );

  // new noise, squared blur change scaled
  assign rsum  = 35'(q1) + 35'(ONE_Q16);
  assign r_new = (rsum > 35'h0FFFFFFFF) ? 32'hFFFFFFFF : rsum[31:0];
  assign qdd   = 40'(d1_c.qd) * 40'(d1_c.d);
  assign ppsum = 41'(s4_c.p) + 41'(s4_qdd);
  assign num2  = DIV_NUM_W'({s6_c.pp, 16'h0000}) + DIV_NUM_W'(s6_den[DIV_DEN_W-1:1]);

  kbpf_div u_div_k (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (s6_vld),
    .num     (num2),
    .den     (s6_den),
    .in_ctx  (s6_c),
    .probe   (in_addr),
    .out_vld (d2_vld),
    .quo     (q2),
    .out_ctx (d2_c),
    .hit     (d2_hit)
  );

  // blends
  assign s8_omk  = ONE_Q16 - s8_kn;
  assign s10_omk = ONE_Q16 - s10_kn;
  assign xpsum   = s9_ma + {s9_mb, 16'h0000} + 41'(HALF_Q16);
  assign psum    = s9_mp + 49'(HALF_Q16);
  assign xsum    = s11_mc + {s11_md, 16'h0000} + 41'(HALF_Q16);

  // write back and output pixel: rounded estimate, or the raw pixel on a load
  always_comb begin
    wr_en = s12_vld && adv;
    if (s12_c.load) begin
      wr_data.est = {s12_c.z, 16'h0000};
      wr_data.p   = 32'(ONE_Q16);
      wr_data.k   = HALF_Q16;
      wr_data.r   = 32'(noise_init);
      wr_data.pb  = '0;
      pix         = s12_c.z;
      rnd         = '0;
    end else begin
      wr_data.est = s12_x;
      wr_data.p   = s12_pnew;
      wr_data.k   = s12_kn;
      wr_data.r   = s12_c.r;
      wr_data.pb  = s12_c.blur;
      rnd         = 9'(s12_x[23:16]) + 9'(s12_x[15]);
      pix         = rnd[8] ? 8'hFF : rnd[7:0];
    end
  end

  // context words entering stages 1, 4 and 5
  always_comb begin
    s1_c_next      = '0;
    s1_c_next.idx  = pixel_index;
    s1_c_next.load = load_first;
    s1_c_next.z    = raw_pixel;
    s1_c_next.blur = box_blurred;
    s1_c_next.bil  = bilateral_value;

    s4_c_next      = d1_c;
    s4_c_next.r    = r_new;

    s5_c_next      = s4_c;
    s5_c_next.pp   = (ppsum > 41'h0FFFFFFFF) ? 32'hFFFFFFFF : ppsum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s4_vld    <= 1'b0;
      s5_vld    <= 1'b0;
      s6_vld    <= 1'b0;
      s8_vld    <= 1'b0;
      s9_vld    <= 1'b0;
      s10_vld   <= 1'b0;
      s11_vld   <= 1'b0;
      s12_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_vld    <= acc;
      s4_vld    <= d1_vld;
      s5_vld    <= s4_vld;
      s6_vld    <= s5_vld;
      s8_vld    <= d2_vld;
      s9_vld    <= s8_vld;
      s10_vld   <= s9_vld;
      s11_vld   <= s10_vld;
      s12_vld   <= s11_vld;
      out_valid <= s12_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_c      <= s1_c_next;

      s4_c      <= s4_c_next;
      s4_qdd    <= qdd;

      s5_c      <= s5_c_next;

      s6_c      <= s5_c;
      s6_den    <= DIV_DEN_W'(s5_c.pp) + DIV_DEN_W'(s5_c.r);

      s8_c      <= d2_c;
      s8_kn     <= (q2 > DIV_Q_W'(ONE_Q16)) ? ONE_Q16 : q2[16:0];

      s9_c      <= s8_c;
      s9_kn     <= s8_kn;
      s9_ma     <= 41'(s8_omk) * 41'(s8_c.est);
      s9_mb     <= 25'(s8_kn) * 25'(s8_c.z);
      s9_mp     <= 49'(s8_c.pp) * 49'(s8_omk);

      s10_c     <= s9_c;
      s10_kn    <= s9_kn;
      s10_xp    <= xpsum[39:16];
      s10_pnew  <= psum[47:16];

      s11_c     <= s10_c;
      s11_kn    <= s10_kn;
      s11_pnew  <= s10_pnew;
      s11_mc    <= 41'(s10_omk) * 41'(s10_xp);
      s11_md    <= 25'(s10_kn) * 25'(s10_c.bil);

      s12_c     <= s11_c;
      s12_kn    <= s11_kn;
      s12_pnew  <= s11_pnew;
      s12_x     <= xsum[39:16];

      out_index      <= s12_c.idx;
      denoised_pixel <= pix;
    end
  end

endmodule
